// ===== hdl/clmd_pkg.sv =====
// Shared types, codes and constants of the Content-Length message deframer.
package clmd_pkg;

  localparam int LENGTH_BITS_DEF = 24;

  localparam logic [4:0] LEN_PREFIX_SIZE  = 5'd16;
  localparam logic [4:0] TYPE_PREFIX_SIZE = 5'd14;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    KIND_BODY        = 3'd0,
    KIND_EMPTY       = 3'd1,
    KIND_UNKNOWN     = 3'd2,
    KIND_MISSING_LEN = 3'd3,
    KIND_END_HEADER  = 3'd4,
    KIND_END_BODY    = 3'd5,
    KIND_OVERFLOW    = 3'd6
  } kind_t;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_t;

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_STOP   = 2'd2
  } num_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] body_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

  // "Content-Length: "
  function automatic logic [7:0] len_prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:  ch = 8'h43; // C
      4'd1:  ch = 8'h6F; // o
      4'd2:  ch = 8'h6E; // n
      4'd3:  ch = 8'h74; // t
      4'd4:  ch = 8'h65; // e
      4'd5:  ch = 8'h6E; // n
      4'd6:  ch = 8'h74; // t
      4'd7:  ch = 8'h2D; // -
      4'd8:  ch = 8'h4C; // L
      4'd9:  ch = 8'h65; // e
      4'd10: ch = 8'h6E; // n
      4'd11: ch = 8'h67; // g
      4'd12: ch = 8'h74; // t
      4'd13: ch = 8'h68; // h
      4'd14: ch = 8'h3A; // :
      default: ch = 8'h20;
    endcase
    return ch;
  endfunction

  // "Content-Type: "
  function automatic logic [7:0] type_prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:  ch = 8'h43; // C
      4'd1:  ch = 8'h6F; // o
      4'd2:  ch = 8'h6E; // n
      4'd3:  ch = 8'h74; // t
      4'd4:  ch = 8'h65; // e
      4'd5:  ch = 8'h6E; // n
      4'd6:  ch = 8'h74; // t
      4'd7:  ch = 8'h2D; // -
      4'd8:  ch = 8'h54; // T
      4'd9:  ch = 8'h79; // y
      4'd10: ch = 8'h70; // p
      4'd11: ch = 8'h65; // e
      4'd12: ch = 8'h3A; // :
      4'd13: ch = 8'h20; // space
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/content_length_message_deframer.sv =====
// Top level of the Content-Length message deframer: input stage, parser, result register.
//
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_stall   in_data  (data_byte, end_of_input)
//   out_     out  out_valid/out_stall out_data (kind, body_byte, last)
//
// One byte per clock sustained while results are taken. A taken byte waits in the input stage
// register until the parser steps it; any result it yields is loaded into the output register.
// The parser updates its framing state in the same cycle that it loads the result.
// The input stage keeps taking bytes while a result waits, until both registers hold.
// Reset clears the valid flags and returns the parser to a fresh header.
module content_length_message_deframer #(
  parameter int LENGTH_BITS = clmd_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clmd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output clmd_pkg::out_item_t out_data
);
  import clmd_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      out_load, step;
  step_res_t res;

  assign out_load = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = out_load ? (step && res.valid) : out_valid_r;

  clmd_hdr #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_hdr (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (s1_item_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (step && res.valid && out_load) begin
      out_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a held input byte stays put while the result register is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input stage lost or changed a held transaction");

  a_nonbody_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.kind != KIND_BODY)) |-> out_data_r.last)
    else $error("non-body result without last");

  a_nonbody_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.kind != KIND_BODY)) |-> (out_data_r.body_byte == 8'h00))
    else $error("non-body result carries a data byte");

  a_no_step_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r && out_load) |=> !out_valid_r)
    else $error("result produced without an input transaction");

endmodule

// ===== hdl/clmd_hdr.sv =====
// Header parser and body counter: all framing state, one byte per step.
module clmd_hdr #(
  parameter int LENGTH_BITS = clmd_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  clmd_pkg::in_item_t  item,
  output clmd_pkg::step_res_t res
);
  import clmd_pkg::*;

  localparam int VW = LENGTH_BITS + 1;
  localparam logic [VW-1:0] CAP = {1'b1, {LENGTH_BITS{1'b0}}};

  phase_t                 phase_r, phase_nxt;
  logic                   cr_armed_r, cr_armed_nxt;
  logic [4:0]             line_pos_r, line_pos_nxt;
  logic                   len_match_r, len_match_nxt;
  logic                   type_match_r, type_match_nxt;
  num_phase_t             num_phase_r, num_phase_nxt;
  logic                   num_neg_r, num_neg_nxt;
  logic [VW-1:0]          num_val_r, num_val_nxt;
  logic                   len_known_r, len_known_nxt;
  logic [VW-1:0]          body_len_r, body_len_nxt;
  logic [LENGTH_BITS-1:0] remaining_r, remaining_nxt;

  logic [7:0]    c;
  logic          is_digit, is_blank, acc, do_clear, do_fresh, last_byte;
  logic [3:0]    digit_val;
  logic [VW+3:0] prod;

  assign c         = item.data_byte;
  assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_blank  = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  assign digit_val = 4'(c - CHAR_ZERO);
  // value * 10 + digit, with room for the saturated magnitude
  assign prod = ({4'b0, num_val_r} << 3) + ({4'b0, num_val_r} << 1)
              + {{VW{1'b0}}, digit_val};
  assign last_byte = (remaining_r <= LENGTH_BITS'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      cr_armed_r   <= 1'b0;
      line_pos_r   <= '0;
      len_match_r  <= 1'b1;
      type_match_r <= 1'b1;
      num_phase_r  <= NUM_SKIP;
      num_neg_r    <= 1'b0;
      num_val_r    <= '0;
      len_known_r  <= 1'b0;
      body_len_r   <= '0;
      remaining_r  <= '0;
    end else begin
      phase_r      <= phase_nxt;
      cr_armed_r   <= cr_armed_nxt;
      line_pos_r   <= line_pos_nxt;
      len_match_r  <= len_match_nxt;
      type_match_r <= type_match_nxt;
      num_phase_r  <= num_phase_nxt;
      num_neg_r    <= num_neg_nxt;
      num_val_r    <= num_val_nxt;
      len_known_r  <= len_known_nxt;
      body_len_r   <= body_len_nxt;
      remaining_r  <= remaining_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    cr_armed_nxt   = cr_armed_r;
    line_pos_nxt   = line_pos_r;
    len_match_nxt  = len_match_r;
    type_match_nxt = type_match_r;
    num_phase_nxt  = num_phase_r;
    num_neg_nxt    = num_neg_r;
    num_val_nxt    = num_val_r;
    len_known_nxt  = len_known_r;
    body_len_nxt   = body_len_r;
    remaining_nxt  = remaining_r;
    res            = '0;
    acc            = 1'b0;
    do_clear       = 1'b0;
    do_fresh       = 1'b0;

    if (step) begin
      if (item.end_of_input) begin
        res.valid     = 1'b1;
        res.item.kind = (phase_r == PH_BODY) ? KIND_END_BODY : KIND_END_HEADER;
        res.item.last = 1'b1;
        do_fresh      = 1'b1;
      end else if (phase_r == PH_BODY) begin
        res.valid          = 1'b1;
        res.item.kind      = KIND_BODY;
        res.item.body_byte = c;
        res.item.last      = last_byte;
        if (last_byte) begin
          do_fresh = 1'b1;
        end else begin
          remaining_nxt = remaining_r - LENGTH_BITS'(1);
        end
      end else if (!cr_armed_r && (c == CHAR_CR)) begin
        cr_armed_nxt = 1'b1;
      end else if (cr_armed_r && (c == CHAR_LF)) begin
        // line end
        if (line_pos_r == 5'd0) begin
          res.item.last = 1'b1;
          if (!len_known_r) begin
            res.valid     = 1'b1;
            res.item.kind = KIND_MISSING_LEN;
            do_fresh      = 1'b1;
          end else if (body_len_r >= CAP) begin
            res.valid     = 1'b1;
            res.item.kind = KIND_OVERFLOW;
            do_fresh      = 1'b1;
          end else if (body_len_r == '0) begin
            res.valid     = 1'b1;
            res.item.kind = KIND_EMPTY;
            do_fresh      = 1'b1;
          end else begin
            res.item.last = 1'b0;
            remaining_nxt = body_len_r[LENGTH_BITS-1:0];
            phase_nxt     = PH_BODY;
            do_clear      = 1'b1;
          end
        end else if (len_match_r && (line_pos_r >= LEN_PREFIX_SIZE)) begin
          if (num_neg_r) begin
            // minus one means no length; other negatives become zero
            len_known_nxt = (num_val_r != VW'(1));
            body_len_nxt  = '0;
          end else begin
            len_known_nxt = 1'b1;
            body_len_nxt  = num_val_r;
          end
          do_clear = 1'b1;
        end else if (type_match_r && (line_pos_r >= TYPE_PREFIX_SIZE)) begin
          do_clear = 1'b1;
        end else begin
          res.valid     = 1'b1;
          res.item.kind = KIND_UNKNOWN;
          res.item.last = 1'b1;
          do_fresh      = 1'b1;
        end
      end else if (line_pos_r < LEN_PREFIX_SIZE) begin
        if (c != len_prefix_char(line_pos_r[3:0])) begin
          len_match_nxt = 1'b0;
        end
        if ((line_pos_r < TYPE_PREFIX_SIZE) && (c != type_prefix_char(line_pos_r[3:0]))) begin
          type_match_nxt = 1'b0;
        end
        line_pos_nxt = line_pos_r + 5'd1;
      end else if (len_match_r) begin
        case (num_phase_r)
          NUM_SKIP: begin
            if (is_blank) begin
              num_phase_nxt = NUM_SKIP;
            end else if (c == CHAR_PLUS) begin
              num_phase_nxt = NUM_DIGITS;
            end else if (c == CHAR_MINUS) begin
              num_phase_nxt = NUM_DIGITS;
              num_neg_nxt   = 1'b1;
            end else if (is_digit) begin
              num_phase_nxt = NUM_DIGITS;
              acc           = 1'b1;
            end else begin
              num_phase_nxt = NUM_STOP;
            end
          end
          NUM_DIGITS: begin
            if (is_digit) begin
              acc = 1'b1;
            end else begin
              num_phase_nxt = NUM_STOP;
            end
          end
          default: begin
            num_phase_nxt = num_phase_r;
          end
        endcase
        if (acc) begin
          num_val_nxt = (prod > {4'b0, CAP}) ? CAP : prod[VW-1:0];
        end
      end
    end

    if (do_clear || do_fresh) begin
      cr_armed_nxt   = 1'b0;
      line_pos_nxt   = '0;
      len_match_nxt  = 1'b1;
      type_match_nxt = 1'b1;
      num_phase_nxt  = NUM_SKIP;
      num_neg_nxt    = 1'b0;
      num_val_nxt    = '0;
    end
    if (do_fresh) begin
      phase_nxt     = PH_HEADER;
      len_known_nxt = 1'b0;
      body_len_nxt  = '0;
      remaining_nxt = '0;
    end
  end

endmodule
